// ----- hw/rtl/nv21rgb_pkg.sv -----
// Package for the NV21 chroma-upsampling RGB converter.
// Item structs, BT.601 coefficients, the chroma interpolation function and the shift-clamp helper.
// No dependencies.
package nv21rgb_pkg;

    typedef struct packed {
        logic [7:0] luma;
        logic       col_odd;
        logic       row_odd;
        logic [7:0] v_top_left;
        logic [7:0] v_top_right;
        logic [7:0] v_bottom_left;
        logic [7:0] v_bottom_right;
        logic [7:0] u_top_left;
        logic [7:0] u_top_right;
        logic [7:0] u_bottom_left;
        logic [7:0] u_bottom_right;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    // Centred samples, products and sums
    typedef logic signed [8:0]  t_cen;
    typedef logic signed [19:0] t_prod;
    typedef logic signed [20:0] t_sum;

    localparam logic signed [11:0] C_Y   = 12'sd298;
    localparam logic signed [11:0] C_RV  = 12'sd409;
    localparam logic signed [11:0] C_GU  = 12'sd100;
    localparam logic signed [11:0] C_GV  = 12'sd208;
    localparam logic signed [11:0] C_BU  = 12'sd516;
    localparam logic        [7:0]  CHROMA_BIAS = 8'd128;
    localparam logic        [7:0]  LUMA_BIAS   = 8'd16;
    localparam logic        [7:0]  PIX_MAX     = 8'd255;

    // Bilinear weights are one, one half or one quarter at this position: floored averages
    function automatic logic [7:0] interp(
        input logic [7:0] tl,
        input logic [7:0] tr,
        input logic [7:0] bl,
        input logic [7:0] br,
        input logic       codd,
        input logic       rodd
    );
        logic [9:0] sum4;
        logic [8:0] sum_h;
        logic [8:0] sum_v;
        logic [7:0] res;
        sum4  = {2'b00, tl} + {2'b00, tr} + {2'b00, bl} + {2'b00, br};
        sum_h = {1'b0, tl} + {1'b0, tr};
        sum_v = {1'b0, tl} + {1'b0, bl};
        unique case ({codd, rodd})
            2'b11:   res = sum4[9:2];
            2'b10:   res = sum_h[8:1];
            2'b01:   res = sum_v[8:1];
            default: res = tl;
        endcase
        return res;
    endfunction

    // Arithmetic shift by 8, clamp to 0..255
    function automatic logic [7:0] shift_clamp(input t_sum s);
        logic [7:0] res;
        if (s[20]) begin
            res = 8'd0;
        end else if (s[19:16] != 4'd0) begin
            res = PIX_MAX;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/nv21_bilinear_chroma_to_rgb.sv -----
// NV21 4:2:0 limited-range BT.601 pixel to full-range RGB, four register stages.
// Uses nv21rgb_pkg for the item structs, coefficients and helpers.
//
// Usage:
//   Input channel i_valid / i_pix / o_stall carries one pixel per item: luma,
//   column and row parity and the edge-clamped V and U neighbours at each corner.
//   Output channel o_valid / o_pix / i_stall returns one RGB item per input.
//   Stages: chroma interpolation, coefficient multiplies, channel sums, then
//   shift, clamp and output register. Throughput is one item per clock while
//   the receiver does not stall; there is no state between pixels.
//   A stall from the receiver holds the output register and backs up through
//   the stages; empty stages still fill, so up to four items are held before
//   o_stall rises. o_stall follows i_stall combinationally through the
//   per-stage ready chain. Nothing is dropped or repeated under stall.
//   Reset (synchronous, active low) empties every stage; payload registers are
//   left as they are.
module nv21_bilinear_chroma_to_rgb (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  nv21rgb_pkg::t_pix_in  i_pix,
    output logic                  o_valid,
    input  logic                  i_stall,
    output nv21rgb_pkg::t_pix_out o_pix
);
    import nv21rgb_pkg::*;

    // Stage valid bits
    logic r_v1, r_v2, r_v3, r_vo;
    logic rdy1, rdy2, rdy3, rdyo;

    // Stage 1: centred samples
    t_cen r_ys, r_vs, r_us;
    // Stage 2: products
    t_prod r_yp, r_rv, r_gu, r_gv, r_bu;
    // Stage 3: channel sums
    t_sum r_rs, r_gs, r_bs;
    // Output register
    t_pix_out r_pix;

    t_cen n_ys, n_vs, n_us;
    t_prod n_yp;
    logic [7:0] v_int, u_int;

    assign rdyo    = !r_vo || !i_stall;
    assign rdy3    = !r_v3 || rdyo;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    always_comb begin
        v_int = interp(i_pix.v_top_left, i_pix.v_top_right, i_pix.v_bottom_left,
                       i_pix.v_bottom_right, i_pix.col_odd, i_pix.row_odd);
        u_int = interp(i_pix.u_top_left, i_pix.u_top_right, i_pix.u_bottom_left,
                       i_pix.u_bottom_right, i_pix.col_odd, i_pix.row_odd);
        n_ys  = $signed({1'b0, i_pix.luma}) - $signed({1'b0, LUMA_BIAS});
        n_vs  = $signed({1'b0, v_int}) - $signed({1'b0, CHROMA_BIAS});
        n_us  = $signed({1'b0, u_int}) - $signed({1'b0, CHROMA_BIAS});
        // rounding term rides with the luma product
        n_yp  = t_prod'(r_ys) * t_prod'(C_Y) + $signed({12'd0, CHROMA_BIAS});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdyo) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_ys <= n_ys;
            r_vs <= n_vs;
            r_us <= n_us;
        end
        if (rdy2 && r_v1) begin
            r_yp <= n_yp;
            r_rv <= t_prod'(r_vs) * t_prod'(C_RV);
            r_gu <= t_prod'(r_us) * t_prod'(C_GU);
            r_gv <= t_prod'(r_vs) * t_prod'(C_GV);
            r_bu <= t_prod'(r_us) * t_prod'(C_BU);
        end
        if (rdy3 && r_v2) begin
            r_rs <= 21'(r_yp) + 21'(r_rv);
            r_gs <= 21'(r_yp) - 21'(r_gu) - 21'(r_gv);
            r_bs <= 21'(r_yp) + 21'(r_bu);
        end
        if (rdyo && r_v3) begin
            r_pix.red   <= shift_clamp(r_rs);
            r_pix.green <= shift_clamp(r_gs);
            r_pix.blue  <= shift_clamp(r_bs);
        end
    end

    assign o_valid = r_vo;
    assign o_pix   = r_pix;

endmodule

// ----- hw/rtl/nv21rgb_chk.sv -----
// Port-level checker for nv21_bilinear_chroma_to_rgb, bound to that module.
// Uses nv21rgb_pkg for the item structs.
module nv21rgb_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input nv21rgb_pkg::t_pix_in  i_pix,
    input logic                  o_valid,
    input logic                  i_stall,
    input nv21rgb_pkg::t_pix_out o_pix
);
    import nv21rgb_pkg::*;

    // A held output item stays put while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pix))
        else $error("output item changed under stall");

    // Back-pressure only when every stage is full, so the output must be stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output side free");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output item present after reset");

    // With the receiver never stalling, an accepted item reaches o_valid without being held in any stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_stall ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid)
        else $error("item not delivered at expected latency");

endmodule

bind nv21_bilinear_chroma_to_rgb nv21rgb_chk u_nv21rgb_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_pix   (i_pix),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pix   (o_pix)
);
